// ----- hw/rtl/cos_ms_pkg.sv -----
// Shared types, constants, reciprocal table and microcode program for the cosine series core.
package cos_ms_pkg;

   // Field widths fixed by the interface.
   localparam int ANGLE_W      = 16;
   localparam int COS_W        = 18;
   localparam int TERM_COUNT_W = 4;

   // Defaults for the top-level parameters.
   localparam int MAX_TERMS_DEF  = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int TERM_COUNT_RST = 6;

   // Fixed-point formats of x squared and the reciprocal table.
   localparam int X2_FRAC     = 13;
   localparam int X2_W        = 18;
   localparam int RECIP_W     = 24;
   localparam int RECIP_DEPTH = 32;
   localparam int RECIP_IDX_W = 5;

   // Output clipping limits.
   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN = -131072;

   // Entry k holds round(2^24 / ((2n-1)(2n))) for term n = k + 1.
   localparam logic [RECIP_W-1:0] RECIP_ROM [RECIP_DEPTH] = '{
      24'd8388608, 24'd1398101, 24'd559241, 24'd299593,
      24'd186414,  24'd127100,  24'd92183,  24'd69905,
      24'd54828,   24'd44151,   24'd36314,  24'd30394,
      24'd25811,   24'd22192,   24'd19284,  24'd16913,
      24'd14953,   24'd13315,   24'd11933,  24'd10755,
      24'd9743,    24'd8867,    24'd8105,   24'd7437,
      24'd6848,    24'd6326,    24'd5862,   24'd5447,
      24'd5075,    24'd4739,    24'd4436,   24'd4161
   };

   // Sequencer steps; the step counter holds one of these.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_SQUARE = 3'd1,
      ST_X2     = 3'd2,
      ST_TERM_A = 3'd3,
      ST_TERM_B = 3'd4,
      ST_OUT    = 3'd5
   } step_type;

   // Multiplier operand A sources.
   typedef enum logic [1:0] {
      A_MAG  = 2'd0,
      A_TERM = 2'd1,
      A_PART = 2'd2
   } a_sel_type;

   // Multiplier operand B sources.
   typedef enum logic [1:0] {
      B_MAG   = 2'd0,
      B_X2    = 2'd1,
      B_RECIP = 2'd2
   } b_sel_type;

   // Product register update.
   typedef enum logic [1:0] {
      PROD_HOLD = 2'd0,
      PROD_MUL  = 2'd1,
      PROD_ONE  = 2'd2
   } prod_op_type;

   // Jump conditions.
   typedef enum logic [1:0] {
      COND_NEVER    = 2'd0,
      COND_ALWAYS   = 2'd1,
      COND_NO_START = 2'd2,
      COND_LAST     = 2'd3
   } cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      logic        load;
      a_sel_type   a_sel;
      b_sel_type   b_sel;
      prod_op_type prod_op;
      logic        x2_we;
      logic        acc_en;
      logic        n_inc;
      logic        rsp_load;
      cond_type    cond;
      step_type    target;
   } ucode_type;

   // The microprogram ROM.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type uc;
      uc = '{load: 1'b0, a_sel: A_MAG, b_sel: B_MAG, prod_op: PROD_HOLD,
             x2_we: 1'b0, acc_en: 1'b0, n_inc: 1'b0, rsp_load: 1'b0,
             cond: COND_NEVER, target: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            // Wait for a start, then capture the angle and term count.
            uc.load   = 1'b1;
            uc.cond   = COND_NO_START;
            uc.target = ST_IDLE;
         end
         ST_SQUARE: begin
            // Square the angle magnitude.
            uc.a_sel   = A_MAG;
            uc.b_sel   = B_MAG;
            uc.prod_op = PROD_MUL;
         end
         ST_X2: begin
            // Keep x squared and seed the product so that the first term is one.
            uc.x2_we   = 1'b1;
            uc.prod_op = PROD_ONE;
         end
         ST_TERM_A: begin
            // Accumulate the current term and multiply it by x squared.
            uc.acc_en  = 1'b1;
            uc.a_sel   = A_TERM;
            uc.b_sel   = B_X2;
            uc.prod_op = PROD_MUL;
            uc.cond    = COND_LAST;
            uc.target  = ST_OUT;
         end
         ST_TERM_B: begin
            // Scale the partial product by the reciprocal of the next term.
            uc.a_sel   = A_PART;
            uc.b_sel   = B_RECIP;
            uc.prod_op = PROD_MUL;
            uc.n_inc   = 1'b1;
            uc.cond    = COND_ALWAYS;
            uc.target  = ST_TERM_A;
         end
         ST_OUT: begin
            // Clip the sum and present the result.
            uc.rsp_load = 1'b1;
            uc.cond     = COND_ALWAYS;
            uc.target   = ST_IDLE;
         end
         default: begin
            uc.cond   = COND_ALWAYS;
            uc.target = ST_IDLE;
         end
      endcase
      return uc;
   endfunction

endpackage

// ----- hw/rtl/cosine_maclaurin_series_core.sv -----
// Microcoded fixed-point cosine by its Maclaurin series.
// An accepted angle runs through the square, x-squared, term and output steps; the term steps cover
// term_count clipped to MAX_TERMS terms, and every term after the first takes two passes through one shared multiplier.
// One angle at a time: a start is taken only in the idle step, and busy is high in every other step.
// The receiver cannot stall; each result beat is valid for exactly one cycle.
// Reset (synchronous, active high) returns the sequencer to idle and sets term_count to 6.
module cosine_maclaurin_series_core
   import cos_ms_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [ANGLE_W-1:0]      req_angle,
   output logic                           rsp_valid,
   output logic signed [COS_W-1:0]        rsp_cos_value,
   output logic                           rsp_saturated,
   input  logic                           csr_wr_en,
   input  logic        [TERM_COUNT_W-1:0] csr_wr_data
);

   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int A_W    = FRAC_BITS + 9;
   localparam int PROD_W = A_W + RECIP_W;
   localparam int ACC_W  = (FRAC_BITS + 10 > COS_W + 1) ? FRAC_BITS + 10 : COS_W + 1;
   localparam int WIDE_W = RECIP_IDX_W + 1;

   localparam logic [PROD_W:0]          HALF_X2   = (PROD_W + 1)'(1) << (X2_FRAC - 1);
   localparam logic [PROD_W:0]          HALF_RCP  = (PROD_W + 1)'(1) << (RECIP_W - 1);
   localparam logic [PROD_W-1:0]        PROD_ONE_V = PROD_W'(1) << (FRAC_BITS + RECIP_W);
   localparam logic signed [ACC_W-1:0]  ACC_MAX   = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0]  ACC_MIN   = ACC_W'(OUT_MIN);
   localparam logic [WIDE_W-1:0]        TERMS_MAX = WIDE_W'(MAX_TERMS);

   step_type                   pc_ff, pc_in;
   ucode_type                  uc;
   logic                       load_go;
   logic [TERM_COUNT_W-1:0]    term_count_ff, term_count_in;
   logic [ANGLE_W-1:0]         mag_ff, mag_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [X2_W-1:0]            x2_ff, x2_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [COS_W-1:0]    rsp_cos_ff, rsp_cos_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic [PROD_W:0]            rnd_x2_sum, rnd_rcp_sum;
   logic [A_W-1:0]             term_rnd, part_rnd;
   logic [A_W-1:0]             op_a;
   logic [RECIP_W-1:0]         op_b;
   logic [PROD_W-1:0]          mul_out;
   logic [WIDE_W-1:0]          n_wide, tc_wide, cnt_wide;
   logic signed [ACC_W-1:0]    term_ext;
   logic                       last_term;

   // Current control word and handshake.
   assign uc       = ucode_rom(pc_ff);
   assign busy     = (pc_ff != ST_IDLE);
   assign load_go  = uc.load && start;
   assign last_term = (n_ff == cnt_ff);

   // Rounded views of the product register.
   assign rnd_x2_sum  = {1'b0, prod_ff} + HALF_X2;
   assign rnd_rcp_sum = {1'b0, prod_ff} + HALF_RCP;
   assign part_rnd    = rnd_x2_sum[X2_FRAC +: A_W];
   assign term_rnd    = rnd_rcp_sum[RECIP_W +: A_W];

   // Shared multiplier with its operand selection.
   assign n_wide = WIDE_W'(n_ff);
   always_comb begin
      unique case (uc.a_sel)
         A_MAG:   op_a = A_W'(mag_ff);
         A_TERM:  op_a = term_rnd;
         A_PART:  op_a = part_rnd;
         default: op_a = '0;
      endcase
      unique case (uc.b_sel)
         B_MAG:   op_b = RECIP_W'(mag_ff);
         B_X2:    op_b = RECIP_W'(x2_ff);
         B_RECIP: op_b = RECIP_ROM[n_wide[RECIP_IDX_W-1:0]];
         default: op_b = '0;
      endcase
   end
   assign mul_out = PROD_W'(op_a) * PROD_W'(op_b);

   // Term count clipped to MAX_TERMS.
   assign tc_wide  = WIDE_W'(term_count_ff);
   assign cnt_wide = (tc_wide > TERMS_MAX) ? TERMS_MAX : tc_wide;

   // Datapath next values.
   assign term_ext = ACC_W'(term_rnd);
   always_comb begin
      term_count_in = csr_wr_en ? csr_wr_data : term_count_ff;
      mag_in = mag_ff;
      cnt_in = cnt_ff;
      n_in   = n_ff;
      acc_in = acc_ff;
      if (load_go) begin
         mag_in = req_angle[ANGLE_W-1] ? ANGLE_W'(-req_angle) : req_angle;
         cnt_in = cnt_wide[CNT_W-1:0];
         n_in   = '0;
         acc_in = '0;
      end else begin
         if (uc.n_inc) begin
            n_in = n_ff + CNT_W'(1);
         end
         // Odd terms are subtracted, even terms added.
         if (uc.acc_en) begin
            acc_in = n_ff[0] ? (acc_ff - term_ext) : (acc_ff + term_ext);
         end
      end
      x2_in = uc.x2_we ? rnd_x2_sum[X2_FRAC +: X2_W] : x2_ff;
      unique case (uc.prod_op)
         PROD_HOLD: prod_in = prod_ff;
         PROD_MUL:  prod_in = mul_out;
         PROD_ONE:  prod_in = PROD_ONE_V;
         default:   prod_in = prod_ff;
      endcase
   end

   // Step counter with conditional jumps.
   always_comb begin
      unique case (uc.cond)
         COND_NEVER:    pc_in = step_type'(3'(pc_ff + 3'd1));
         COND_ALWAYS:   pc_in = uc.target;
         COND_NO_START: pc_in = start ? step_type'(3'(pc_ff + 3'd1)) : uc.target;
         COND_LAST:     pc_in = last_term ? uc.target : step_type'(3'(pc_ff + 3'd1));
         default:       pc_in = ST_IDLE;
      endcase
   end

   // Output clipping and result beat.
   always_comb begin
      rsp_valid_in = uc.rsp_load;
      rsp_cos_in   = rsp_cos_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (uc.rsp_load) begin
         priority if (acc_ff > ACC_MAX) begin
            rsp_cos_in = COS_W'(OUT_MAX);
            rsp_sat_in = 1'b1;
         end else if (acc_ff < ACC_MIN) begin
            rsp_cos_in = COS_W'(OUT_MIN);
            rsp_sat_in = 1'b1;
         end else begin
            rsp_cos_in = acc_ff[COS_W-1:0];
            rsp_sat_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= ST_IDLE;
         term_count_ff <= TERM_COUNT_W'(TERM_COUNT_RST);
         rsp_valid_ff  <= 1'b0;
         n_ff          <= '0;
         cnt_ff        <= '0;
      end else begin
         pc_ff         <= pc_in;
         term_count_ff <= term_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         n_ff          <= n_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      x2_ff      <= x2_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      rsp_cos_ff <= rsp_cos_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cos_value = rsp_cos_ff;
   assign rsp_saturated = rsp_sat_ff;

   // A result beat follows only the output step.
   a_beat_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(pc_ff == ST_OUT))
      else $error("result beat without output step");

   // An accepted angle keeps the core busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting an angle");

   // The term index never runs past the clipped term count.
   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> (n_ff <= cnt_ff))
      else $error("term index beyond term count");

   // A saturated result sits on one of the clipping limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_cos_value == COS_W'(OUT_MAX) || rsp_cos_value == COS_W'(OUT_MIN)))
      else $error("saturated flag without clipped value");

endmodule

// ----- tb/sv/cosine_maclaurin_series_core_tb.sv -----
// Self-checking testbench for the fixed-point cosine series core.
`timescale 1ns / 1ps

module cosine_maclaurin_series_core_tb;
   import cos_ms_pkg::*;

   // One result beat as the block presents it.
   typedef struct {
      logic signed [COS_W-1:0] cos_value;
      logic                    saturated;
   } cos_beat_type;

   // Holds the register copy, computes each cosine and checks result beats in order.
   class cos_scoreboard;
      int unsigned  term_count = TERM_COUNT_RST;
      cos_beat_type pending_cos[$];
      int unsigned  errors = 0;

      // Add half an output LSB, then drop the low bits.
      function longint unsigned round_shift(longint unsigned v, int unsigned sh);
         return (v + (64'd1 << (sh - 1))) >> sh;
      endfunction

      // Series sum on unsigned term magnitudes, with alternating signs and clipping.
      function cos_beat_type series_cosine(logic signed [ANGLE_W-1:0] angle, int unsigned terms);
         longint unsigned mag;
         longint unsigned x2;
         longint unsigned term_mag;
         longint unsigned part;
         longint unsigned denom;
         longint unsigned recip;
         longint          acc;
         int unsigned     count;
         cos_beat_type    beat;
         mag = angle[ANGLE_W-1] ? (64'd65536 - 64'(angle[ANGLE_W-1:0]))
                                : 64'(angle[ANGLE_W-1:0]);
         x2 = round_shift(mag * mag, X2_FRAC);
         count = (terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : terms;
         term_mag = 64'd1 << FRAC_BITS_DEF;
         acc = longint'(64'd1 << FRAC_BITS_DEF);
         for (int unsigned n = 1; n <= count; n++) begin
            part = round_shift(term_mag * x2, X2_FRAC);
            denom = longint'((2 * n - 1) * (2 * n));
            recip = ((64'd1 << RECIP_W) + denom / 2) / denom;
            term_mag = round_shift(part * recip, RECIP_W);
            if (n % 2 == 1) begin
               acc -= longint'(term_mag);
            end else begin
               acc += longint'(term_mag);
            end
         end
         beat.saturated = 1'b0;
         if (acc > OUT_MAX) begin
            acc = longint'(OUT_MAX);
            beat.saturated = 1'b1;
         end else if (acc < OUT_MIN) begin
            acc = longint'(OUT_MIN);
            beat.saturated = 1'b1;
         end
         beat.cos_value = acc[COS_W-1:0];
         return beat;
      endfunction

      // An angle was accepted: queue its cosine under the current term count.
      function void note_angle(logic signed [ANGLE_W-1:0] angle);
         pending_cos.push_back(series_cosine(angle, term_count));
      endfunction

      // A result beat arrived: compare it with the oldest queued cosine.
      function void check_beat(logic signed [COS_W-1:0] cos_value, logic saturated);
         cos_beat_type want;
         if (pending_cos.size() == 0) begin
            $error("result beat with nothing pending: cos_value %0d saturated %0d",
                   cos_value, saturated);
            errors++;
            return;
         end
         want = pending_cos.pop_front();
         if (cos_value !== want.cos_value) begin
            $error("cos_value: expected %0d, actual %0d", want.cos_value, cos_value);
            errors++;
         end
         if (saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic signed [ANGLE_W-1:0]      req_angle = '0;
   logic                           rsp_valid;
   logic signed [COS_W-1:0]        rsp_cos_value;
   logic                           rsp_saturated;
   logic                           csr_wr_en = 1'b0;
   logic        [TERM_COUNT_W-1:0] csr_wr_data = '0;

   cos_scoreboard sb = new();

   cosine_maclaurin_series_core DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_angle    (req_angle),
      .rsp_valid    (rsp_valid),
      .rsp_cos_value(rsp_cos_value),
      .rsp_saturated(rsp_saturated),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result beats are checked at the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_beat(rsp_cos_value, rsp_saturated);
      end
   end

   // Present one angle and hold it until the block takes the beat.
   task automatic send_angle(logic signed [ANGLE_W-1:0] angle);
      @(negedge clock);
      start <= 1'b1;
      req_angle <= angle;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_angle(angle);
   endtask

   // Keep start low for the given number of cycles.
   task automatic hold_off(int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop sending and wait until every pending cosine has come back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_cos.size() != 0 || busy) @(posedge clock);
   endtask

   // Write the term count while the block is idle.
   task automatic write_term_count(logic [TERM_COUNT_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= TERM_COUNT_W'($urandom);
      sb.term_count = 32'(value);
   endtask

   // Mostly full-range angles, with some near zero, near the range ends and near pi.
   function automatic logic signed [ANGLE_W-1:0] random_angle();
      int unsigned pick;
      int          offset;
      pick = $urandom_range(0, 9);
      offset = $urandom_range(0, 255);
      case (pick)
         6: return ANGLE_W'(($urandom_range(0, 1) ? 1 : -1) * offset);
         7: return $urandom_range(0, 1) ? ANGLE_W'(32767 - offset)
                                        : ANGLE_W'(-32768 + offset);
         8: return ANGLE_W'(($urandom_range(0, 1) ? 1 : -1) * (25736 + offset - 128));
         default: return ANGLE_W'($urandom);
      endcase
   endfunction

   // Stimulus: directed angles, then random phases under different term counts.
   initial begin
      int unsigned idle_pct;
      int unsigned gap;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset term count of six: zero, smallest steps, range ends, one radian, quarter and half turn.
      send_angle(16'sd0);
      send_angle(16'sd1);
      send_angle(-16'sd1);
      send_angle(16'sh7FFF);
      send_angle(16'sh8000);
      send_angle(16'sd8192);
      send_angle(-16'sd8192);
      send_angle(16'sd12868);
      send_angle(16'sd25736);
      drain();

      // Zero terms: the result is exactly one.
      write_term_count(4'd0);
      send_angle(16'sd0);
      send_angle(16'sh7FFF);
      send_angle(16'sh8000);
      drain();

      // Largest term count, with alternating bit patterns.
      write_term_count(4'd15);
      send_angle(16'sh7FFF);
      send_angle(16'sh8000);
      send_angle(16'sd25736);
      send_angle(16'sd0);
      send_angle(16'sh5555);
      send_angle(16'shAAAA);
      drain();

      // One term at the largest magnitude gives the most negative sum.
      write_term_count(4'd1);
      send_angle(16'sh8000);
      send_angle(16'sh7FFF);
      drain();

      // Random phases; the sender idles less, then more, then not at all.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0, 5:    write_term_count(4'd15);
            1:       write_term_count(4'd0);
            3:       write_term_count(4'd1);
            default: write_term_count(TERM_COUNT_W'($urandom_range(0, 15)));
         endcase
         idle_pct = (phase < 2) ? 17 : (phase < 4) ? 53 : 0;
         for (int i = 0; i < 250; i++) begin
            if ($urandom_range(0, 199) == 0) begin
               drain();
            end else if ($urandom_range(0, 99) < idle_pct) begin
               gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 4);
               hold_off(gap);
            end
            send_angle(random_angle());
         end
         drain();
      end

      // Give the block time to show any stray result beat.
      repeat (2 * MAX_TERMS_DEF + 10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_cos.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop if the block hangs.
   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
